/* rtl/ecsm_pkg.sv */
// ecsm_pkg: shared widths, register indexes, opcodes and the microcode of the
// elliptic-curve scalar multiplier. No dependencies.
package ecsm_pkg;

  localparam int FIELD_BITS_DEF  = 16;
  localparam int SCALAR_BITS_DEF = 16;
  localparam int CFG_IDX_BITS    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_A     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_B     = 2'd2;

  localparam logic [15:0] PRIME_RST = 16'd65521;
  localparam logic [15:0] A_RST     = 16'd0;
  localparam logic [15:0] B_RST     = 16'd7;

  // register file slots (working memory, 32 entries)
  localparam int SLOT_BITS = 5;
  localparam int RF_DEPTH  = 32;
  localparam logic [4:0] S_AX = 5'd0,  S_AY = 5'd1,  S_AZ = 5'd2;
  localparam logic [4:0] S_DX = 5'd3,  S_DY = 5'd4,  S_DZ = 5'd5;
  localparam logic [4:0] S_T0 = 5'd6,  S_T1 = 5'd7,  S_T2 = 5'd8,  S_T3 = 5'd9;
  localparam logic [4:0] S_T4 = 5'd10, S_T5 = 5'd11, S_T6 = 5'd12, S_T7 = 5'd13;
  localparam logic [4:0] S_W  = 5'd14, S_U3 = 5'd15, S_E0 = 5'd16, S_E1 = 5'd17;
  localparam logic [4:0] S_E2 = 5'd18, S_A  = 5'd19, S_ZERO = 5'd20, S_ONE = 5'd21;
  localparam logic [4:0] S_TWO = 5'd22, S_THREE = 5'd23, S_R = 5'd24, S_B = 5'd25;
  localparam logic [4:0] S_NX = 5'd26, S_NY = 5'd27, S_NZ = 5'd28;

  // field operations
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } uop_t;

  function automatic uop_t mk(logic [1:0] op, logic [4:0] d, logic [4:0] a,
                              logic [4:0] b);
    uop_t u;
    u.op = op; u.dst = d; u.src_a = a; u.src_b = b;
    return u;
  endfunction

  // doubling of D into (NX,NY,NZ); E0..E2 scratch
  localparam int DBL_LEN = 19;
  function automatic uop_t dbl_rom(logic [4:0] i);
    uop_t u;
    case (i)
      5'd0:  u = mk(OP_MUL, S_E0, S_DX, S_DX);
      5'd1:  u = mk(OP_MUL, S_E0, S_THREE, S_E0);
      5'd2:  u = mk(OP_MUL, S_E1, S_DZ, S_DZ);
      5'd3:  u = mk(OP_MUL, S_E1, S_A, S_E1);
      5'd4:  u = mk(OP_ADD, S_T0, S_E0, S_E1);     // t
      5'd5:  u = mk(OP_MUL, S_E0, S_TWO, S_DY);
      5'd6:  u = mk(OP_MUL, S_T1, S_E0, S_DZ);     // u
      5'd7:  u = mk(OP_MUL, S_E0, S_TWO, S_T1);
      5'd8:  u = mk(OP_MUL, S_E0, S_E0, S_DX);
      5'd9:  u = mk(OP_MUL, S_T2, S_E0, S_DY);     // v
      5'd10: u = mk(OP_MUL, S_E0, S_T0, S_T0);
      5'd11: u = mk(OP_MUL, S_E1, S_TWO, S_T2);
      5'd12: u = mk(OP_SUB, S_T3, S_E0, S_E1);     // w
      5'd13: u = mk(OP_MUL, S_T4, S_T1, S_DY);     // u*y
      5'd14: u = mk(OP_MUL, S_NX, S_T1, S_T3);
      5'd15: u = mk(OP_SUB, S_E0, S_T2, S_T3);
      5'd16: u = mk(OP_MUL, S_E0, S_T0, S_E0);
      5'd17: u = mk(OP_MUL, S_E1, S_T4, S_T4);
      default: u = mk(OP_MUL, S_E1, S_TWO, S_E1);
    endcase
    return u;
  endfunction
  // tail of doubling (after index 18)
  localparam int DBL2_LEN = 3;
  function automatic uop_t dbl2_rom(logic [4:0] i);
    uop_t u;
    case (i)
      5'd0:    u = mk(OP_SUB, S_NY, S_E0, S_E1);
      5'd1:    u = mk(OP_MUL, S_E2, S_T1, S_T1);
      default: u = mk(OP_MUL, S_NZ, S_E2, S_T1);
    endcase
    return u;
  endfunction

  // addition, first part: A + D, cross products
  localparam int ADD1_LEN = 4;
  function automatic uop_t add1_rom(logic [4:0] i);
    uop_t u;
    case (i)
      5'd0:    u = mk(OP_MUL, S_T0, S_AY, S_DZ);
      5'd1:    u = mk(OP_MUL, S_T1, S_DY, S_AZ);
      5'd2:    u = mk(OP_MUL, S_T2, S_AX, S_DZ);
      default: u = mk(OP_MUL, S_T3, S_DX, S_AZ);
    endcase
    return u;
  endfunction

  localparam int ADD2_LEN = 17;
  function automatic uop_t add2_rom(logic [4:0] i);
    uop_t u;
    case (i)
      5'd0:  u = mk(OP_SUB, S_T4, S_T0, S_T1);
      5'd1:  u = mk(OP_SUB, S_T5, S_T2, S_T3);
      5'd2:  u = mk(OP_MUL, S_T6, S_T5, S_T5);
      5'd3:  u = mk(OP_MUL, S_T7, S_AZ, S_DZ);
      5'd4:  u = mk(OP_MUL, S_E0, S_T4, S_T4);
      5'd5:  u = mk(OP_MUL, S_E0, S_E0, S_T7);
      5'd6:  u = mk(OP_ADD, S_E1, S_T2, S_T3);
      5'd7:  u = mk(OP_MUL, S_E1, S_T6, S_E1);
      5'd8:  u = mk(OP_SUB, S_W, S_E0, S_E1);
      5'd9:  u = mk(OP_MUL, S_U3, S_T6, S_T5);
      5'd10: u = mk(OP_MUL, S_E0, S_T2, S_T6);
      5'd11: u = mk(OP_SUB, S_E0, S_E0, S_W);
      5'd12: u = mk(OP_MUL, S_E0, S_T4, S_E0);
      5'd13: u = mk(OP_MUL, S_E1, S_T0, S_U3);
      5'd14: u = mk(OP_SUB, S_AY, S_E0, S_E1);
      5'd15: u = mk(OP_MUL, S_AX, S_T5, S_W);
      default: u = mk(OP_MUL, S_AZ, S_U3, S_T7);
    endcase
    return u;
  endfunction

endpackage

/* rtl/ecsm_if.sv */
// ecsm_if: valid/ready channel carrying a generic payload
// depends on nothing
interface ecsm_if #(parameter int W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ecsm_ram.sv */
// ecsm_ram: generic single-port-write, single-read synchronous RAM
// registered read data, no dependencies
module ecsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/ecsm_alu.sv */
// ecsm_alu: multi-cycle modular multiply/add/sub over the field
// depends on ecsm_pkg; shift-and-add multiplier, one bit per cycle
module ecsm_alu #(
  parameter int FW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    op,
  input  logic [FW-1:0] opa,
  input  logic [FW-1:0] opb,
  input  logic [FW-1:0] modulus,
  output logic          done,
  output logic [FW-1:0] res
);
  import ecsm_pkg::*;

  localparam int CW = $clog2(FW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0] acc_r, acc_nxt;
  logic [FW-1:0] a_r, a_nxt;
  logic [FW-1:0] b_r, b_nxt;
  logic          done_r, done_nxt;
  logic [FW:0]   dbl, dbl_red, addv, addv_red, sum, sumr, diff;
  logic [FW-1:0] ar, br;

  // operand reduction: stored values and the small constants need at most one
  // subtract; a raw value only ever enters as the multiplier b, whose bits may
  // be any value congruent to the operand
  assign ar = (opa >= modulus) ? opa - modulus : opa;
  assign br = (opb >= modulus) ? opb - modulus : opb;

  // one bit of the multiplier, msb first: acc = 2*acc (+ a); also modular a+b and a-b
  always_comb begin
    dbl      = {acc_r, 1'b0};
    dbl_red  = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    addv     = dbl_red + {1'b0, a_r};
    addv_red = (addv >= {1'b0, modulus}) ? addv - {1'b0, modulus} : addv;
    sum      = {1'b0, ar} + {1'b0, br};
    sumr     = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    diff     = {1'b0, ar} + {1'b0, modulus} - {1'b0, br};
    if (diff >= {1'b0, modulus}) begin
      diff = diff - {1'b0, modulus};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    done_nxt = 1'b0;
    if (start) begin
      case (op)
        OP_ADD: begin
          acc_nxt  = sumr[FW-1:0];
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          acc_nxt  = diff[FW-1:0];
          done_nxt = 1'b1;
        end
        default: begin
          busy_nxt = 1'b1;
          cnt_nxt  = CW'(FW);
          acc_nxt  = '0;
          a_nxt    = ar;
          b_nxt    = br;
        end
      endcase
    end else if (busy_r) begin
      acc_nxt = b_r[FW-1] ? addv_red[FW-1:0] : dbl_red[FW-1:0];
      b_nxt   = {b_r[FW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;
endmodule

/* rtl/ecc_scalar_point_multiply.sv */
// ecc_scalar_point_multiply: top level, sequencer over a working RAM and the field ALU
// depends on ecsm_pkg, ecsm_if, ecsm_ram, ecsm_alu
//
// usage
//   in channel (sink): {scalar, point_is_infinity, point_y, point_x}; one item is
//   taken only when the block is idle. out channel (source): {result_is_infinity,
//   result_y, result_x}, one result per item.
//   cfg port: cfg_we, cfg_idx, cfg_data; write only while idle.
// operation counts
//   each field multiply has two RAM reads, operand load, start, one bit per cycle
//   and write-back; add/sub has the same steps without the bit loop. a doubling is 18
//   multiplies and 7 add/sub, an addition 15 multiplies and 6 add/sub, the final
//   inversion FIELD_BITS squarings plus one multiply per set bit of p-2.
//   a new item is not taken until the last result is out; all field operations
//   share the single multiplier (the ALU).
// reset
//   synchronous active-low; registers go to prime 65521 and a 0, sequencer idle.
//   the working RAM needs no clearing: every slot is written before use.
// stall
//   the result is held in an output register until taken; no new item is
//   accepted until then.
module ecc_scalar_point_multiply #(
  parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
  parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ecsm_if.sink                            in_ch,
  ecsm_if.source                          out_ch,
  input  logic                            cfg_we,
  input  logic [ecsm_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [FIELD_BITS-1:0]           cfg_data
);
  import ecsm_pkg::*;

  localparam int FW = FIELD_BITS;
  localparam int SW = SCALAR_BITS;
  localparam int EW = $clog2(FW + 1);

  // state codes
  localparam logic [4:0] ST_IDLE = 5'd0,  ST_LOAD = 5'd1,  ST_LOOP = 5'd2;
  localparam logic [4:0] ST_RDA  = 5'd3,  ST_RDB = 5'd4,   ST_EXE = 5'd5;
  localparam logic [4:0] ST_CHK  = 5'd6,  ST_CMP = 5'd7,   ST_OUT = 5'd8;
  localparam logic [4:0] ST_DONE = 5'd9,  ST_RDQ = 5'd10,  ST_RDQ2 = 5'd11;
  localparam logic [4:0] ST_FIN  = 5'd12, ST_INV = 5'd13;

  // program codes
  localparam logic [3:0] PG_ADD1 = 4'd0, PG_ADD2 = 4'd1, PG_DBL = 4'd2;
  localparam logic [3:0] PG_DBL2 = 4'd3, PG_CPY = 4'd4, PG_NCPY = 4'd5;
  localparam logic [3:0] PG_INVSQ = 4'd6, PG_INVML = 4'd7, PG_NORM = 4'd8;
  localparam logic [3:0] PG_INIT = 4'd9, PG_CHKD = 4'd10, PG_RDAX = 4'd11;

  logic [FW-1:0] prime_r, a_r;
  logic [FW-1:0] mod_w;

  logic [4:0]    st_r, st_nxt;
  logic [3:0]    pg_r, pg_nxt;
  logic [4:0]    pc_r, pc_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic          dbl_is_acc_r, dbl_is_acc_nxt;
  logic [EW-1:0] ebit_r, ebit_nxt;
  logic [FW-1:0] e_r, e_nxt;
  logic [FW-1:0] hold_r, hold_nxt;
  logic [FW-1:0] cmp_r, cmp_nxt;
  logic [2:0]    sub_r, sub_nxt;
  logic          flag_r, flag_nxt;
  logic [FW-1:0] px_r, py_r;
  logic          pinf_r;
  logic [FW-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic          oinf_r, oinf_nxt, ov_r, ov_nxt;

  // RAM ports
  logic          we;
  logic [4:0]    waddr, raddr;
  logic [FW-1:0] wdata, rdata;

  // ALU
  logic          alu_start, alu_done;
  logic [1:0]    alu_op;
  logic [FW-1:0] opa_r, opa_nxt, alu_res;
  uop_t          u;

  assign mod_w = (prime_r < FW'(3)) ? FW'(3) : prime_r;

  ecsm_ram #(.WIDTH(FW), .DEPTH(RF_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ecsm_alu #(.FW(FW)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_start), .op(alu_op), .opa(opa_r),
    .opb(rdata), .modulus(mod_w), .done(alu_done), .res(alu_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= FW'(PRIME_RST);
      a_r     <= FW'(A_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PRIME: prime_r <= cfg_data;
        CFG_A:     a_r     <= cfg_data;
        default:   ;
      endcase
    end
  end

  // current microinstruction
  always_comb begin
    case (pg_r)
      PG_ADD1: u = add1_rom(pc_r);
      PG_ADD2: u = add2_rom(pc_r);
      PG_DBL:  u = dbl_rom(pc_r);
      PG_DBL2: u = dbl2_rom(pc_r);
      // copy D into A, one coordinate per pc value, via add with zero
      PG_CPY: begin
        case (pc_r)
          5'd0:    u = mk(OP_ADD, S_AX, S_DX, S_ZERO);
          5'd1:    u = mk(OP_ADD, S_AY, S_DY, S_ZERO);
          default: u = mk(OP_ADD, S_AZ, S_DZ, S_ZERO);
        endcase
      end
      PG_NCPY: begin
        case (pc_r)
          5'd0:    u = mk(OP_ADD, dbl_is_acc_r ? S_AX : S_DX, S_NX, S_ZERO);
          5'd1:    u = mk(OP_ADD, dbl_is_acc_r ? S_AY : S_DY, S_NY, S_ZERO);
          default: u = mk(OP_ADD, dbl_is_acc_r ? S_AZ : S_DZ, S_NZ, S_ZERO);
        endcase
      end
      PG_INVSQ: u = mk(OP_MUL, S_B, S_B, S_B);
      PG_INVML: u = mk(OP_MUL, S_R, S_R, S_B);
      PG_NORM: begin
        case (pc_r)
          5'd0:    u = mk(OP_MUL, S_E0, S_AX, S_R);
          default: u = mk(OP_MUL, S_E1, S_AY, S_R);
        endcase
      end
      default: u = mk(OP_ADD, S_E0, S_ZERO, S_ZERO);
    endcase
  end

  // when doubling the accumulator, the doubling program reads A instead of D
  function automatic logic [4:0] remap(logic [4:0] s, logic acc);
    logic [4:0] r;
    r = s;
    if (acc) begin
      case (s)
        S_DX:    r = S_AX;
        S_DY:    r = S_AY;
        S_DZ:    r = S_AZ;
        default: r = s;
      endcase
    end
    return r;
  endfunction

  logic prg_dbl;
  assign prg_dbl = (pg_r == PG_DBL) || (pg_r == PG_DBL2);
  assign in_ch.ready = (st_r == ST_IDLE) && !ov_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; pg_nxt = pg_r; pc_nxt = pc_r; k_nxt = k_r;
    dbl_is_acc_nxt = dbl_is_acc_r; ebit_nxt = ebit_r; e_nxt = e_r;
    hold_nxt = hold_r; cmp_nxt = cmp_r; sub_nxt = sub_r; flag_nxt = flag_r;
    opa_nxt = opa_r;
    ox_nxt = ox_r; oy_nxt = oy_r; oinf_nxt = oinf_r; ov_nxt = ov_r;
    we = 1'b0; waddr = u.dst; wdata = alu_res; raddr = S_ZERO;
    alu_start = 1'b0; alu_op = u.op;
    if (out_ch.valid && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          st_nxt = ST_LOAD; sub_nxt = '0;
          k_nxt = in_ch.data[2*FW+1 +: SW];
        end
      end
      // write constants and the base point into the RAM, one per cycle
      ST_LOAD: begin
        we = 1'b1; sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: begin waddr = S_ZERO; wdata = '0; end
          3'd1: begin waddr = S_ONE;  wdata = FW'(1); end
          3'd2: begin waddr = S_TWO;  wdata = FW'(2); end
          3'd3: begin waddr = S_THREE; wdata = FW'(3); end
          3'd4: begin waddr = S_A;    wdata = a_r; end
          3'd5: begin waddr = S_DX;   wdata = pinf_r ? '0 : px_r; end
          3'd6: begin waddr = S_DY;   wdata = pinf_r ? FW'(1) : py_r; end
          default: begin
            waddr = S_DZ; wdata = pinf_r ? '0 : FW'(1);
            st_nxt = ST_CMP; pg_nxt = PG_INIT; pc_nxt = '0;
          end
        endcase
      end
      // reduce A slot (a) and the base coordinates modulo p via multiply by one
      ST_CMP: begin
        case (pc_r)
          5'd0: begin raddr = S_A; sub_nxt = 3'd0; end
          5'd1: begin raddr = S_DX; end
          default: begin raddr = S_DY; end
        endcase
        st_nxt = ST_RDQ;
      end
      ST_RDQ: begin
        opa_nxt = FW'(1); st_nxt = ST_RDQ2;
        raddr = (pc_r == 5'd0) ? S_A : (pc_r == 5'd1) ? S_DX : S_DY;
      end
      ST_RDQ2: begin
        alu_start = 1'b1; alu_op = OP_MUL; st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (alu_done) begin
          we = 1'b1; wdata = alu_res;
          case (pc_r)
            5'd0: waddr = S_A;
            5'd1: waddr = S_DX;
            default: waddr = S_DY;
          endcase
          if (pc_r == 5'd2) begin
            // accumulator = infinity
            st_nxt = ST_INV; sub_nxt = 3'd0; pc_nxt = '0;
          end else begin
            pc_nxt = pc_r + 5'd1; st_nxt = ST_CMP;
          end
        end
      end
      // set A to infinity, then enter the main loop; else step the inversion loop
      ST_INV: begin
        if (pg_r == PG_INIT) begin
          we = 1'b1; sub_nxt = sub_r + 3'd1;
          case (sub_r)
            3'd0: begin waddr = S_AX; wdata = '0; end
            3'd1: begin waddr = S_AY; wdata = FW'(1); end
            default: begin waddr = S_AZ; wdata = '0; st_nxt = ST_LOOP; end
          endcase
        end else begin
          // inversion exponent loop over bits of p-2, lsb first
          if (ebit_r == '0) begin
            pg_nxt = PG_NORM; pc_nxt = '0; st_nxt = ST_RDA;
          end else if (sub_r == 3'd0) begin
            sub_nxt = 3'd1;
            if (e_r[0]) begin
              pg_nxt = PG_INVML; pc_nxt = '0; st_nxt = ST_RDA;
            end
          end else begin
            sub_nxt = 3'd0; pg_nxt = PG_INVSQ; pc_nxt = '0; st_nxt = ST_RDA;
          end
        end
      end
      // main loop: examine scalar
      ST_LOOP: begin
        if (k_r == '0) begin
          st_nxt = ST_CHK; pg_nxt = PG_RDAX; sub_nxt = 3'd0;
        end else if (k_r[0] && !flag_r) begin
          // addition: first check special cases on A and D
          st_nxt = ST_CHK; pg_nxt = PG_CHKD; sub_nxt = 3'd0;
        end else begin
          dbl_is_acc_nxt = 1'b0;
          st_nxt = ST_CHK; pg_nxt = PG_DBL; sub_nxt = 3'd0;
        end
      end
      // read checks: x, y, z of one point (A and D for an add) decide special cases
      ST_CHK: begin
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: raddr = (pg_r == PG_DBL && !dbl_is_acc_r) ? S_DX :
                        (pg_r == PG_DBL) ? S_AX : S_AX;
          3'd1: raddr = (pg_r == PG_DBL && !dbl_is_acc_r) ? S_DY :
                        (pg_r == PG_DBL) ? S_AY : S_AY;
          3'd2: raddr = (pg_r == PG_DBL && !dbl_is_acc_r) ? S_DZ :
                        (pg_r == PG_DBL) ? S_AZ : S_AZ;
          3'd3: raddr = S_DX;
          3'd4: raddr = S_DY;
          default: raddr = S_DZ;
        endcase
        // rdata is the word addressed in the previous cycle; hold x, y, z and flags
        case (sub_r)
          3'd1, 3'd4: hold_nxt = rdata;               // x of a point
          3'd2, 3'd5: cmp_nxt = rdata;                // y of a point
          default: ;
        endcase
        if (sub_r == 3'd3) begin
          // rdata = z of first point
          if (pg_r == PG_DBL) begin
            if ((hold_r == '0 && cmp_r == FW'(1) && rdata == '0) || cmp_r == '0) begin
              // result infinity: write (0,1,0) into the doubled point in ST_OUT
              st_nxt = ST_OUT; sub_nxt = 3'd0;
            end else begin
              pc_nxt = '0; st_nxt = ST_RDA;
            end
          end else if (pg_r == PG_RDAX) begin
            if (rdata == '0) begin
              ox_nxt = {{(FW-1){1'b0}}, hold_r != '0};
              oy_nxt = {{(FW-1){1'b0}}, cmp_r != '0};
              oinf_nxt = 1'b1; ov_nxt = 1'b1; st_nxt = ST_IDLE;
            end else begin
              // inversion: R = 1, B = z, exponent p-2
              st_nxt = ST_OUT; sub_nxt = 3'd4; hold_nxt = rdata;
            end
          end else begin
            flag_nxt = (hold_r == '0 && cmp_r == FW'(1) && rdata == '0);
          end
        end
        if (pg_r == PG_CHKD && sub_r == 3'd3) begin
          st_nxt = ST_CHK;
        end
        if (pg_r == PG_CHKD && sub_r == 3'd6) begin
          // rdata = z of D; dispatch
          sub_nxt = 3'd0;
          if (flag_r) begin
            // A infinity: A := D
            pg_nxt = PG_CPY; pc_nxt = '0; st_nxt = ST_RDA;
          end else if (hold_r == '0 && cmp_r == FW'(1) && rdata == '0) begin
            // D infinity: A unchanged, go on to double D
            dbl_is_acc_nxt = 1'b0; pg_nxt = PG_DBL; pc_nxt = '0;
            st_nxt = ST_CHK; flag_nxt = 1'b1;
          end else begin
            pg_nxt = PG_ADD1; pc_nxt = '0; st_nxt = ST_RDA;
          end
        end
      end
      // microinstruction: read operand a
      ST_RDA: begin
        raddr = prg_dbl ? remap(u.src_a, dbl_is_acc_r) : u.src_a;
        st_nxt = ST_RDB;
      end
      ST_RDB: begin
        raddr = prg_dbl ? remap(u.src_b, dbl_is_acc_r) : u.src_b;
        opa_nxt = rdata; st_nxt = ST_EXE;
      end
      ST_EXE: begin
        raddr = prg_dbl ? remap(u.src_b, dbl_is_acc_r) : u.src_b;
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        raddr = prg_dbl ? remap(u.src_b, dbl_is_acc_r) : u.src_b;
        alu_start = 1'b1; st_nxt = ST_OUT; sub_nxt = 3'd7;
      end
      // write back, advance program; also used for special-case writes
      ST_OUT: begin
        if (sub_r == 3'd7) begin
          if (alu_done) begin
            we = 1'b1;
            st_nxt = ST_RDA;
            sub_nxt = 3'd0;
            pc_nxt = pc_r + 5'd1;
            case (pg_r)
              PG_ADD1: begin
                if (pc_r == 5'(ADD1_LEN - 1)) begin
                  // compare u0/u1 and t0/t1
                  st_nxt = ST_LOOP; flag_nxt = 1'b0;
                  pg_nxt = PG_ADD1; sub_nxt = 3'd0;
                  st_nxt = ST_CMP; pc_nxt = 5'd16;
                end
              end
              PG_ADD2: if (pc_r == 5'(ADD2_LEN - 1)) begin
                dbl_is_acc_nxt = 1'b0; pg_nxt = PG_DBL; pc_nxt = '0;
                st_nxt = ST_CHK; sub_nxt = 3'd0; flag_nxt = 1'b1;
              end
              PG_DBL: if (pc_r == 5'(DBL_LEN - 1)) begin
                pg_nxt = PG_DBL2; pc_nxt = '0;
              end
              PG_DBL2: if (pc_r == 5'(DBL2_LEN - 1)) begin
                pg_nxt = PG_NCPY; pc_nxt = '0;
              end
              PG_CPY: if (pc_r == 5'd2) begin
                dbl_is_acc_nxt = 1'b0; pg_nxt = PG_DBL; pc_nxt = '0;
                st_nxt = ST_CHK; sub_nxt = 3'd0; flag_nxt = 1'b1;
              end
              PG_NCPY: if (pc_r == 5'd2) begin
                if (dbl_is_acc_r) begin
                  dbl_is_acc_nxt = 1'b0; pg_nxt = PG_DBL; pc_nxt = '0;
                  st_nxt = ST_CHK; sub_nxt = 3'd0; flag_nxt = 1'b1;
                end else begin
                  k_nxt = k_r >> 1; flag_nxt = 1'b0; st_nxt = ST_LOOP;
                end
              end
              PG_INVSQ, PG_INVML: begin
                st_nxt = ST_INV;
                if (pg_r == PG_INVSQ) begin
                  e_nxt = e_r >> 1; ebit_nxt = ebit_r - 1'b1; sub_nxt = 3'd0;
                end else begin
                  sub_nxt = 3'd1;
                end
              end
              PG_NORM: if (pc_r == 5'd1) begin
                st_nxt = ST_RDQ; pg_nxt = PG_RDAX; sub_nxt = 3'd5;
              end
              default: ;
            endcase
          end
        end else if (sub_r == 3'd4) begin
          // inversion setup: R = 1, B = z
          we = 1'b1; waddr = S_R; wdata = FW'(1); sub_nxt = 3'd5;
        end else if (sub_r == 3'd5) begin
          we = 1'b1; waddr = S_B; wdata = hold_r; sub_nxt = 3'd0;
          e_nxt = mod_w - FW'(2); ebit_nxt = EW'(FW);
          pg_nxt = PG_INVSQ; st_nxt = ST_INV;
        end else begin
          // doubling to infinity: write (0,1,0) into the doubled point
          we = 1'b1; sub_nxt = sub_r + 3'd1;
          case (sub_r)
            3'd0: begin waddr = dbl_is_acc_r ? S_AX : S_DX; wdata = '0; end
            3'd1: begin waddr = dbl_is_acc_r ? S_AY : S_DY; wdata = FW'(1); end
            default: begin
              waddr = dbl_is_acc_r ? S_AZ : S_DZ; wdata = '0;
              if (dbl_is_acc_r) begin
                dbl_is_acc_nxt = 1'b0; pg_nxt = PG_DBL; pc_nxt = '0;
                st_nxt = ST_CHK; sub_nxt = 3'd0; flag_nxt = 1'b1;
              end else begin
                k_nxt = k_r >> 1; flag_nxt = 1'b0; st_nxt = ST_LOOP;
              end
            end
          endcase
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    // post-add compare of cross products (pg ADD1, pc 16..)
    if (st_r == ST_CMP && pg_r == PG_ADD1) begin
      we = 1'b0; alu_start = 1'b0;
      case (pc_r)
        5'd16: begin raddr = S_T2; pc_nxt = 5'd17; end
        5'd17: begin raddr = S_T3; pc_nxt = 5'd18; hold_nxt = rdata; end
        5'd18: begin raddr = S_T0; pc_nxt = 5'd19; flag_nxt = (rdata == hold_r); end
        5'd19: begin raddr = S_T1; pc_nxt = 5'd20; hold_nxt = rdata; end
        5'd20: begin pc_nxt = 5'd21; cmp_nxt = rdata; end
        default: begin
          pc_nxt = '0; sub_nxt = 3'd0;
          if (!flag_r) begin
            pg_nxt = PG_ADD2; st_nxt = ST_RDA;
          end else if (cmp_r == hold_r) begin
            dbl_is_acc_nxt = 1'b1; pg_nxt = PG_DBL; st_nxt = ST_CHK;
          end else begin
            dbl_is_acc_nxt = 1'b1; st_nxt = ST_OUT; pg_nxt = PG_DBL;
          end
          flag_nxt = 1'b0;
        end
      endcase
      st_nxt = (pc_r < 5'd21) ? ST_CMP : st_nxt;
    end
    // final normalize read-out (PG_RDAX, sub 5/6)
    if (st_r == ST_RDQ && pg_r == PG_RDAX) begin
      raddr = S_E1; st_nxt = ST_RDQ2;
      if (sub_r == 3'd5) begin
        raddr = S_E0; sub_nxt = 3'd6;
        st_nxt = ST_RDQ;
      end else begin
        hold_nxt = rdata; sub_nxt = 3'd7;
      end
    end
    if (st_r == ST_RDQ2 && pg_r == PG_RDAX) begin
      alu_start = 1'b0;
      ox_nxt = hold_r; oy_nxt = rdata; oinf_nxt = 1'b0; ov_nxt = 1'b1;
      st_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pg_r <= PG_INIT;
      pc_r <= '0;
      sub_r <= '0;
      flag_r <= 1'b0;
      dbl_is_acc_r <= 1'b0;
      ov_r <= 1'b0;
      k_r <= '0;
      ebit_r <= '0;
    end else begin
      st_r <= st_nxt;
      pg_r <= (st_r == ST_IDLE) ? PG_INIT : pg_nxt;
      pc_r <= (st_r == ST_IDLE) ? '0 : pc_nxt;
      sub_r <= sub_nxt;
      flag_r <= (st_r == ST_IDLE) ? 1'b0 : flag_nxt;
      dbl_is_acc_r <= dbl_is_acc_nxt;
      ov_r <= ov_nxt;
      k_r <= k_nxt;
      ebit_r <= ebit_nxt;
    end
    e_r <= e_nxt;
    hold_r <= hold_nxt;
    cmp_r <= cmp_nxt;
    opa_r <= opa_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    oinf_r <= oinf_nxt;
    if (in_ch.valid && in_ch.ready) begin
      px_r <= in_ch.data[FW-1:0];
      py_r <= in_ch.data[2*FW-1:FW];
      pinf_r <= in_ch.data[2*FW];
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = {oinf_r, oy_r, ox_r};

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r) else $error("result dropped");
  a_inf_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oinf_r) |-> (ox_r <= FW'(1) && oy_r <= FW'(1)))
    else $error("bad infinity encoding");
endmodule
